@@ sv/epq_pkg.sv @@
package epq_pkg;

    // angle and quaternion fixed point
    localparam int ANGLE_FB = 8;
    localparam int QUAT_FB = 14;

    // full turn of the heading and period of the half angle, in angle units
    localparam int FULL_TURN = 360 << ANGLE_FB;
    localparam int HALF_PERIOD = 720 << ANGLE_FB;
    localparam int W_BITS = ANGLE_FB + 10;

    // heading wrap by restoring compare-subtract
    localparam int U_W = 26;
    localparam longint HEAD_OFF = ((longint'(1) << 23) / FULL_TURN + 1) * FULL_TURN;
    localparam int HSTEPS = 26 - $clog2(FULL_TURN);
    localparam int HSPLIT = HSTEPS / 2;

    // half-angle period is PH_DIV * 2^(ANGLE_FB + 4)
    localparam int PH_DIV = 45;
    localparam int QW_BITS = ANGLE_FB + 4;
    localparam int PT_W = 28 - ANGLE_FB;
    localparam int PH_RND = 22;
    localparam int RW_BITS = $clog2(PH_DIV);
    localparam int RK = W_BITS + 6;
    localparam int RM_BITS = RK - 5;
    localparam longint RECIP_45 = (longint'(1) << RK) / PH_DIV + 1;

    localparam longint Q30_ONE = longint'(1) << 30;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // taylor term divisors k*(k+1)
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam int SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

    // stage counts
    localparam int FRONT_LAT = 2;
    localparam int PHASE_LAT = 5;
    localparam int SC_LAT = 13;
    localparam int QUAT_LAT = 5;
    localparam int TOTAL_LAT = FRONT_LAT + PHASE_LAT + SC_LAT + QUAT_LAT;

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } oct_t;

    typedef logic [PT_W-1:0] ph_tab_t [PH_DIV];

    function automatic ph_tab_t gen_ph_tab();
        ph_tab_t t;
        for (int i = 0; i < PH_DIV; i++)
        begin
            t[i] = PT_W'(((longint'(i) << PT_W) + PH_RND) / PH_DIV);
        end
        return t;
    endfunction

    // low phase bits for each remainder of w / 45
    localparam ph_tab_t PH_TAB = gen_ph_tab();

endpackage

@@ sv/epq_front.sv @@
module epq_front (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [23:0]         heading,
    input  logic signed [16:0]         pitch,
    input  logic signed [16:0]         roll,
    output logic [epq_pkg::W_BITS-1:0] w_head,
    output logic [epq_pkg::W_BITS-1:0] w_pitch,
    output logic [epq_pkg::W_BITS-1:0] w_roll
);
    import epq_pkg::*;

    logic [U_W-1:0]          u1_next;
    logic [U_W-1:0]          u1_reg;
    logic [U_W-1:0]          u2_next;
    logic signed [W_BITS:0]  pn;
    logic signed [W_BITS:0]  rn;
    logic [W_BITS-1:0]       wp1_next;
    logic [W_BITS-1:0]       wr1_next;
    logic [W_BITS-1:0]       wp1_reg;
    logic [W_BITS-1:0]       wr1_reg;
    logic [W_BITS-1:0]       wh_reg;
    logic [W_BITS-1:0]       wp_reg;
    logic [W_BITS-1:0]       wr_reg;

    always_comb
    begin
        // offset makes heading positive, then subtract multiples of a turn
        u1_next = U_W'(heading) + U_W'(HEAD_OFF);
        for (int j = HSTEPS - 1; j >= HSPLIT; j--)
        begin
            if (u1_next >= U_W'(longint'(FULL_TURN) << j))
                u1_next = u1_next - U_W'(longint'(FULL_TURN) << j);
        end

        u2_next = u1_reg;
        for (int j = HSPLIT - 1; j >= 0; j--)
        begin
            if (u2_next >= U_W'(longint'(FULL_TURN) << j))
                u2_next = u2_next - U_W'(longint'(FULL_TURN) << j);
        end

        // pitch is left-handed
        pn = -((W_BITS + 1)'(pitch));
        rn = (W_BITS + 1)'(roll);
        wp1_next = (pn < 0) ? W_BITS'(pn + (W_BITS + 1)'(HALF_PERIOD)) : W_BITS'(pn);
        wr1_next = (rn < 0) ? W_BITS'(rn + (W_BITS + 1)'(HALF_PERIOD)) : W_BITS'(rn);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg  <= u1_next;
            wp1_reg <= wp1_next;
            wr1_reg <= wr1_next;
            wh_reg  <= W_BITS'(u2_next);
            wp_reg  <= wp1_reg;
            wr_reg  <= wr1_reg;
        end
    end

    assign w_head  = wh_reg;
    assign w_pitch = wp_reg;
    assign w_roll  = wr_reg;

endmodule

@@ sv/epq_phase.sv @@
module epq_phase (
    input  logic                       clk,
    input  logic                       en,
    input  logic [epq_pkg::W_BITS-1:0] w_in,
    output logic [29:0]                x,
    output logic [29:0]                x2,
    output epq_pkg::oct_t              oct
);
    import epq_pkg::*;

    logic [W_BITS+RM_BITS-1:0] prod1_reg;
    logic [W_BITS-1:0]         w1_reg;
    logic [QW_BITS-1:0]        qw_next;
    logic [QW_BITS-1:0]        qw2_reg;
    logic [RW_BITS-1:0]        rw_next;
    logic [RW_BITS-1:0]        rw2_reg;
    logic [31:0]               p_next;
    logic [29:0]               r_next;
    logic [29:0]               rr_next;
    logic [29:0]               rr3_reg;
    oct_t                      oct_next;
    oct_t                      oct3_reg;
    oct_t                      oct4_reg;
    oct_t                      oct5_reg;
    logic [60:0]               xm4_reg;
    logic [29:0]               x_next;
    logic [29:0]               x5_reg;
    logic [59:0]               sq5_reg;

    always_comb
    begin
        // w = 45*qw + rw, phase = qw * 2^PT_W + table(rw)
        qw_next = prod1_reg[RK +: QW_BITS];
        rw_next = RW_BITS'(w1_reg - W_BITS'(W_BITS'(qw_next) * W_BITS'(PH_DIV)));

        p_next = {qw2_reg, PH_TAB[rw2_reg]};
        oct_next.quad = p_next[31:30];
        r_next = p_next[29:0];
        // fold the upper octant onto the lower one
        if (r_next > 30'(Q30_ONE >> 1))
        begin
            rr_next = 30'(31'(Q30_ONE) - 31'(r_next));
            oct_next.swap = 1'b1;
        end
        else
        begin
            rr_next = r_next;
            oct_next.swap = 1'b0;
        end

        x_next = xm4_reg[59:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= (W_BITS + RM_BITS)'(w_in) * (W_BITS + RM_BITS)'(RECIP_45);
            w1_reg    <= w_in;
            qw2_reg   <= qw_next;
            rw2_reg   <= rw_next;
            rr3_reg   <= rr_next;
            oct3_reg  <= oct_next;
            xm4_reg   <= 61'(rr3_reg) * 61'(HALF_PI_Q30);
            oct4_reg  <= oct3_reg;
            x5_reg    <= x_next;
            sq5_reg   <= 60'(x_next) * 60'(x_next);
            oct5_reg  <= oct4_reg;
        end
    end

    assign x   = x5_reg;
    assign x2  = sq5_reg[59:30];
    assign oct = oct5_reg;

endmodule

@@ sv/epq_hstep.sv @@
module epq_hstep #(
    parameter int DIVISOR = 6
) (
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x2_in,
    input  logic [30:0] s_in,
    output logic [30:0] s_out
);
    import epq_pkg::*;

    // reciprocal exact for every 30-bit dividend
    localparam int DL = $clog2(DIVISOR);
    localparam int DK = 30 + DL;
    localparam longint DM = (longint'(1) << DK) / DIVISOR + 1;

    logic [60:0] prod_reg;
    logic [61:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 61'(x2_in) * 61'(s_in);
            q_reg    <= 62'(prod_reg[59:30]) * 62'(DM);
        end
    end

    // one horner step: 1 - (x2 * s) / (k * (k + 1))
    assign s_out = 31'(Q30_ONE) - 31'(q_reg >> DK);

endmodule

@@ sv/epq_sincos.sv @@
module epq_sincos (
    input  logic                clk,
    input  logic                en,
    input  logic [29:0]         x,
    input  logic [29:0]         x2,
    input  epq_pkg::oct_t       oct,
    output epq_pkg::q30_t       sin_q,
    output epq_pkg::q30_t       cos_q
);
    import epq_pkg::*;

    localparam int X2_DEPTH = 2 * (COS_STEPS - 1);
    localparam int X_DEPTH = 2 * SIN_STEPS;
    localparam int OCT_DEPTH = 2 * COS_STEPS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [29:0] x2_dly_reg [X2_DEPTH];
    logic [29:0] x2_tap [X2_DEPTH+1];
    logic [29:0] x_dly_reg [X_DEPTH];
    oct_t        oct_dly_reg [OCT_DEPTH];
    logic [30:0] ss [SIN_STEPS+1];
    logic [30:0] cs [COS_STEPS+1];
    logic [60:0] sx_reg;
    logic [30:0] s0_reg;
    logic [30:0] so;
    logic [30:0] co;
    q30_t        ps;
    q30_t        pc;
    q30_t        sin_next;
    q30_t        cos_next;
    q30_t        sin_reg;
    q30_t        cos_reg;

    assign x2_tap[0] = x2;
    for (genvar k = 1; k <= X2_DEPTH; k++)
    begin : g_tap
        assign x2_tap[k] = x2_dly_reg[k-1];
    end

    assign ss[0] = 31'(Q30_ONE);
    assign cs[0] = 31'(Q30_ONE);

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        epq_hstep #(.DIVISOR(SIN_DIV[i])) u_step (
            .clk   (clk),
            .en    (en),
            .x2_in (x2_tap[2*i]),
            .s_in  (ss[i]),
            .s_out (ss[i+1])
        );
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        epq_hstep #(.DIVISOR(COS_DIV[i])) u_step (
            .clk   (clk),
            .en    (en),
            .x2_in (x2_tap[2*i]),
            .s_in  (cs[i]),
            .s_out (cs[i+1])
        );
    end

    always_comb
    begin
        so = oct_dly_reg[OCT_DEPTH-1].swap ? cs[COS_STEPS] : s0_reg;
        co = oct_dly_reg[OCT_DEPTH-1].swap ? s0_reg : cs[COS_STEPS];
        ps = signed'(32'(so));
        pc = signed'(32'(co));
        unique case (oct_dly_reg[OCT_DEPTH-1].quad)
            QUAD_0:
            begin
                sin_next = ps;
                cos_next = pc;
            end
            QUAD_1:
            begin
                sin_next = pc;
                cos_next = -ps;
            end
            QUAD_2:
            begin
                sin_next = -ps;
                cos_next = -pc;
            end
            QUAD_3:
            begin
                sin_next = -pc;
                cos_next = ps;
            end
            default:
            begin
                sin_next = ps;
                cos_next = pc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < X2_DEPTH; k++)
                x2_dly_reg[k] <= x2_tap[k];
            x_dly_reg[0] <= x;
            for (int k = 1; k < X_DEPTH; k++)
                x_dly_reg[k] <= x_dly_reg[k-1];
            oct_dly_reg[0] <= oct;
            for (int k = 1; k < OCT_DEPTH; k++)
                oct_dly_reg[k] <= oct_dly_reg[k-1];
            // sine series ends with a multiply by x
            sx_reg  <= 61'(x_dly_reg[X_DEPTH-1]) * 61'(ss[SIN_STEPS]);
            s0_reg  <= 31'(sx_reg[59:30]);
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

@@ sv/epq_quat.sv @@
module epq_quat (
    input  logic                clk,
    input  logic                en,
    input  epq_pkg::q30_t       sy,
    input  epq_pkg::q30_t       cy,
    input  epq_pkg::q30_t       sp,
    input  epq_pkg::q30_t       cp,
    input  epq_pkg::q30_t       sr,
    input  epq_pkg::q30_t       cr,
    output logic signed [15:0]  qw,
    output logic signed [15:0]  qx,
    output logic signed [15:0]  qy,
    output logic signed [15:0]  qz
);
    import epq_pkg::*;

    localparam int QS = 30 - QUAT_FB;
    localparam longint QS_HALF = longint'(1) << (QS - 1);
    localparam longint QLIM = longint'(1) << QUAT_FB;

    // round half away from zero of v / 2^30
    function automatic q30_t rnd30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r = (mag + 64'(Q30_ONE >> 1)) >> 30;
        return v[63] ? -q30_t'(r[31:0]) : q30_t'(r[31:0]);
    endfunction

    // move to output fraction with rounding and saturation
    function automatic logic signed [15:0] qout(input logic signed [32:0] v);
        logic [32:0] mag;
        logic [32:0] r;
        mag = v[32] ? 33'(-v) : 33'(v);
        r = (mag + 33'(QS_HALF)) >> QS;
        if (r > 33'(QLIM))
            r = 33'(QLIM);
        return v[32] ? -16'(r) : 16'(r);
    endfunction

    logic signed [63:0] crcp_p_reg;
    logic signed [63:0] srsp_p_reg;
    logic signed [63:0] srcp_p_reg;
    logic signed [63:0] crsp_p_reg;
    q30_t               crcp_reg;
    q30_t               srsp_reg;
    q30_t               srcp_reg;
    q30_t               crsp_reg;
    q30_t               sy1_reg;
    q30_t               cy1_reg;
    q30_t               sy2_reg;
    q30_t               cy2_reg;
    logic signed [63:0] t_reg [8];
    logic signed [32:0] w4_reg;
    logic signed [32:0] x4_reg;
    logic signed [32:0] y4_reg;
    logic signed [32:0] z4_reg;
    logic signed [15:0] qw_reg;
    logic signed [15:0] qx_reg;
    logic signed [15:0] qy_reg;
    logic signed [15:0] qz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_p_reg <= 64'(cr) * 64'(cp);
            srsp_p_reg <= 64'(sr) * 64'(sp);
            srcp_p_reg <= 64'(sr) * 64'(cp);
            crsp_p_reg <= 64'(cr) * 64'(sp);
            sy1_reg    <= sy;
            cy1_reg    <= cy;

            crcp_reg <= rnd30(crcp_p_reg);
            srsp_reg <= rnd30(srsp_p_reg);
            srcp_reg <= rnd30(srcp_p_reg);
            crsp_reg <= rnd30(crsp_p_reg);
            sy2_reg  <= sy1_reg;
            cy2_reg  <= cy1_reg;

            t_reg[0] <= 64'(crcp_reg) * 64'(cy2_reg);
            t_reg[1] <= 64'(srsp_reg) * 64'(sy2_reg);
            t_reg[2] <= 64'(srcp_reg) * 64'(cy2_reg);
            t_reg[3] <= 64'(crsp_reg) * 64'(sy2_reg);
            t_reg[4] <= 64'(crsp_reg) * 64'(cy2_reg);
            t_reg[5] <= 64'(srcp_reg) * 64'(sy2_reg);
            t_reg[6] <= 64'(crcp_reg) * 64'(sy2_reg);
            t_reg[7] <= 64'(srsp_reg) * 64'(cy2_reg);

            w4_reg <= 33'(rnd30(t_reg[0])) + 33'(rnd30(t_reg[1]));
            x4_reg <= 33'(rnd30(t_reg[2])) - 33'(rnd30(t_reg[3]));
            y4_reg <= 33'(rnd30(t_reg[4])) + 33'(rnd30(t_reg[5]));
            z4_reg <= 33'(rnd30(t_reg[6])) - 33'(rnd30(t_reg[7]));

            qw_reg <= qout(w4_reg);
            qx_reg <= qout(x4_reg);
            qy_reg <= qout(y4_reg);
            qz_reg <= qout(z4_reg);
        end
    end

    assign qw = qw_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;
    assign qz = qz_reg;

endmodule

@@ sv/euler_pose_to_quaternion_core.sv @@
// Turns one navigation sample (position in 1/1024 m, heading, pitch and roll in
// 1/256 degree) into one pose: position in 1/1024 mm and a ZYX unit quaternion
// in Q2.14. The block is a 25-stage pipeline that takes a new word every cycle
// while in_stall is low and gives one pose per accepted word, delayed while
// out_stall holds the pipeline. Depth is set mostly by the taylor sine and cosine
// series, two registered multiplies per term; all stages advance together, so
// in_stall is high exactly while a finished pose waits with out_stall high.
module euler_pose_to_quaternion_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] north_pos,
    input  logic signed [31:0] east_pos,
    input  logic signed [31:0] depth_pos,
    input  logic signed [23:0] heading_angle,
    input  logic signed [16:0] pitch_angle,
    input  logic signed [16:0] roll_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [41:0] x_mm,
    output logic signed [41:0] y_mm,
    output logic signed [41:0] z_mm,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z
);
    import epq_pkg::*;

    localparam int POS_SCALE = 1000;
    localparam int POS_DEPTH = TOTAL_LAT - 1;

    logic               en;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic signed [31:0] px_dly_reg [POS_DEPTH];
    logic signed [31:0] py_dly_reg [POS_DEPTH];
    logic signed [31:0] pz_dly_reg [POS_DEPTH];
    logic signed [41:0] x_mm_reg;
    logic signed [41:0] y_mm_reg;
    logic signed [41:0] z_mm_reg;
    logic [W_BITS-1:0]  w_head;
    logic [W_BITS-1:0]  w_pitch;
    logic [W_BITS-1:0]  w_roll;
    logic [29:0]        xa [3];
    logic [29:0]        x2a [3];
    oct_t               octa [3];
    logic [W_BITS-1:0]  wa [3];
    q30_t               sa [3];
    q30_t               ca [3];

    // whole pipeline moves unless a finished word is held
    assign en = !(vld_reg[TOTAL_LAT-1] && out_stall);
    assign in_stall = !en;

    epq_front u_front (
        .clk     (clk),
        .en      (en),
        .heading (heading_angle),
        .pitch   (pitch_angle),
        .roll    (roll_angle),
        .w_head  (w_head),
        .w_pitch (w_pitch),
        .w_roll  (w_roll)
    );

    assign wa[0] = w_head;
    assign wa[1] = w_pitch;
    assign wa[2] = w_roll;

    for (genvar i = 0; i < 3; i++)
    begin : g_angle
        epq_phase u_phase (
            .clk  (clk),
            .en   (en),
            .w_in (wa[i]),
            .x    (xa[i]),
            .x2   (x2a[i]),
            .oct  (octa[i])
        );

        epq_sincos u_sincos (
            .clk   (clk),
            .en    (en),
            .x     (xa[i]),
            .x2    (x2a[i]),
            .oct   (octa[i]),
            .sin_q (sa[i]),
            .cos_q (ca[i])
        );
    end

    epq_quat u_quat (
        .clk (clk),
        .en  (en),
        .sy  (sa[0]),
        .cy  (ca[0]),
        .sp  (sa[1]),
        .cp  (ca[1]),
        .sr  (sa[2]),
        .cr  (ca[2]),
        .qw  (quat_w),
        .qx  (quat_x),
        .qy  (quat_y),
        .qz  (quat_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_dly_reg[0] <= north_pos;
            py_dly_reg[0] <= east_pos;
            pz_dly_reg[0] <= depth_pos;
            for (int k = 1; k < POS_DEPTH; k++)
            begin
                px_dly_reg[k] <= px_dly_reg[k-1];
                py_dly_reg[k] <= py_dly_reg[k-1];
                pz_dly_reg[k] <= pz_dly_reg[k-1];
            end
            x_mm_reg <= 42'(px_dly_reg[POS_DEPTH-1]) * 42'(POS_SCALE);
            y_mm_reg <= 42'(py_dly_reg[POS_DEPTH-1]) * 42'(POS_SCALE);
            z_mm_reg <= 42'(pz_dly_reg[POS_DEPTH-1]) * 42'(POS_SCALE);
        end
    end

    assign out_valid = vld_reg[TOTAL_LAT-1];
    assign x_mm = x_mm_reg;
    assign y_mm = y_mm_reg;
    assign z_mm = z_mm_reg;

    // a held word freezes every stage
    ap_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while output was held");

    // millimetres are a multiple of 1000, so of 8
    ap_pos_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_mm[2:0] == 3'd0 && y_mm[2:0] == 3'd0 && z_mm[2:0] == 3'd0))
        else $error("position not scaled by 1000");

    ap_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384 &&
                       quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
                       quat_y <= 16'sd16384 && quat_y >= -16'sd16384 &&
                       quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
        else $error("quaternion part out of range");

endmodule
